// ===== sv/sce_pkg.sv =====
// Shared definitions for the spatial covariance estimator.
// Holds field widths, register codes, defaults and the lane control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sce_pkg;

	localparam int NUM_CH_DEF       = 4;
	localparam int MAX_SNAPSHOT_DEF = 1024;
	localparam int SAMPLE_BITS_DEF  = 16;

	// Fixed field layout of a transfer.
	localparam int WORD_W     = 64;
	localparam int LANE_PITCH = 16;
	localparam int ENTRY_W    = 33;
	localparam int IDX_W      = 2;
	localparam int OUT_DATA_W = 72;

	localparam int SNAP_W = 11;
	localparam int OVL_W  = 10;
	localparam int GATE_W = 2;

	localparam logic [SNAP_W-1:0] SNAP_RESET = 11'd256;

	localparam logic [1:0] REG_SNAPSHOT = 2'd0;
	localparam logic [1:0] REG_OVERLAP  = 2'd1;
	localparam logic [1:0] REG_FB       = 2'd2;
	localparam logic [1:0] REG_GATING   = 2'd3;

	localparam logic [GATE_W-1:0] GATE_START_INVALID = 2'd1;
	localparam logic [GATE_W-1:0] GATE_START_VALID   = 2'd2;

	typedef struct packed {
		logic clear;
		logic acc;
		logic div_start;
		logic fb;
	} lane_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/sce_lane.sv =====
// One lane of the estimator: owns one matrix row of window sums.
// Updates the row per sample and divides it by the window length (the forward-backward sum by twice that) on request.
// Depends on sce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sce_lane #(
	parameter int NUM_CH      = sce_pkg::NUM_CH_DEF,
	parameter int SAMPLE_BITS = sce_pkg::SAMPLE_BITS_DEF,
	parameter int SUM_W       = 43,
	parameter int LEN_W       = 11,
	parameter int LANE        = 0
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire sce_pkg::lane_ctrl_t                 ctrl,
	input  wire [LEN_W-1:0]                          len,
	input  wire [sce_pkg::WORD_W-1:0]                new_re,
	input  wire [sce_pkg::WORD_W-1:0]                new_im,
	input  wire [sce_pkg::WORD_W-1:0]                old_re,
	input  wire [sce_pkg::WORD_W-1:0]                old_im,
	input  wire [NUM_CH-1:0][SUM_W-1:0]              mir_re,
	input  wire [NUM_CH-1:0][SUM_W-1:0]              mir_im,
	output logic [NUM_CH-1:0][SUM_W-1:0]             own_re,
	output logic [NUM_CH-1:0][SUM_W-1:0]             own_im,
	output logic [NUM_CH-1:0][sce_pkg::ENTRY_W-1:0]  res_re,
	output logic [NUM_CH-1:0][sce_pkg::ENTRY_W-1:0]  res_im,
	output logic                                     done
);

	localparam int SB      = SAMPLE_BITS;
	localparam int MUL_W   = 2 * SB;
	localparam int PROD_W  = MUL_W + 1;
	localparam int DELTA_W = PROD_W + 1;
	localparam int NUM_W   = SUM_W + 1;
	localparam int DIV_W   = LEN_W + 1;
	localparam int CNT_W   = $clog2(NUM_W);
	localparam int COL_W   = $clog2(NUM_CH);
	localparam int PITCH   = sce_pkg::LANE_PITCH;

	logic signed [SB-1:0] nar, nai, oar, oai;

	assign nar = $signed(new_re[LANE*PITCH +: SB]);
	assign nai = $signed(new_im[LANE*PITCH +: SB]);
	assign oar = $signed(old_re[LANE*PITCH +: SB]);
	assign oai = $signed(old_im[LANE*PITCH +: SB]);

	genvar b;
	for (b = 0; b < NUM_CH; b++) begin : g_col
		logic signed [SB-1:0]      nbr, nbi, obr, obi;
		logic signed [MUL_W-1:0]   n0, n1, n2, n3, o0, o1, o2, o3;
		logic signed [PROD_W-1:0]  np_re, np_im, op_re, op_im;
		logic signed [DELTA_W-1:0] d_re_s1, d_im_s1;
		logic signed [SUM_W-1:0]   sum_re_q, sum_im_q;

		assign nbr = $signed(new_re[b*PITCH +: SB]);
		assign nbi = $signed(new_im[b*PITCH +: SB]);
		assign obr = $signed(old_re[b*PITCH +: SB]);
		assign obi = $signed(old_im[b*PITCH +: SB]);

		assign n0 = nar * nbr;
		assign n1 = nai * nbi;
		assign n2 = nai * nbr;
		assign n3 = nar * nbi;
		assign o0 = oar * obr;
		assign o1 = oai * obi;
		assign o2 = oai * obr;
		assign o3 = oar * obi;

		// x_a * conj(x_b) for the new and the departing sample.
		assign np_re = PROD_W'(n0) + PROD_W'(n1);
		assign np_im = PROD_W'(n2) - PROD_W'(n3);
		assign op_re = PROD_W'(o0) + PROD_W'(o1);
		assign op_im = PROD_W'(o2) - PROD_W'(o3);

		always_ff @(posedge clk) begin
			d_re_s1 <= DELTA_W'(np_re) - DELTA_W'(op_re);
			d_im_s1 <= DELTA_W'(np_im) - DELTA_W'(op_im);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sum_re_q <= '0;
				sum_im_q <= '0;
			end else if (ctrl.clear) begin
				sum_re_q <= '0;
				sum_im_q <= '0;
			end else if (ctrl.acc) begin
				sum_re_q <= sum_re_q + SUM_W'(d_re_s1);
				sum_im_q <= sum_im_q + SUM_W'(d_im_s1);
			end
		end

		assign own_re[b] = sum_re_q;
		assign own_im[b] = sum_im_q;
	end

	typedef enum logic [1:0] {LS_IDLE, LS_LOAD, LS_DIV, LS_STORE} lane_state_t;

	lane_state_t             state_q;
	logic [COL_W-1:0]        col_q, mcol;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [NUM_W-1:0] num_re, num_im;
	logic [NUM_W-1:0]        mag_re, mag_im, nm_re_q, nm_im_q;
	logic                    neg_re_q, neg_im_q;
	logic [DIV_W-1:0]        dvs, dvs_q, rem_re_q, rem_im_q, rem_re_nxt, rem_im_nxt;
	logic [DIV_W:0]          rw_re, rw_im;
	logic [DIV_W+1:0]        tr_re, tr_im;
	logic                    ge_re, ge_im;
	logic signed [NUM_W-1:0] q_re, q_im;

	assign mcol = COL_W'(NUM_CH - 1) - col_q;

	// Forward-backward term pairs entry (a,b) with the conjugate of (N-1-a,N-1-b).
	always_comb begin
		if (ctrl.fb) begin
			num_re = NUM_W'($signed(own_re[col_q])) + NUM_W'($signed(mir_re[mcol]));
			num_im = NUM_W'($signed(own_im[col_q])) - NUM_W'($signed(mir_im[mcol]));
			dvs    = {len, 1'b0};
		end else begin
			num_re = NUM_W'($signed(own_re[col_q]));
			num_im = NUM_W'($signed(own_im[col_q]));
			dvs    = {1'b0, len};
		end
		mag_re = num_re[NUM_W-1] ? NUM_W'(-num_re) : NUM_W'(num_re);
		mag_im = num_im[NUM_W-1] ? NUM_W'(-num_im) : NUM_W'(num_im);
	end

	// One restoring division step per cycle on the magnitudes.
	always_comb begin
		rw_re      = {rem_re_q, nm_re_q[NUM_W-1]};
		rw_im      = {rem_im_q, nm_im_q[NUM_W-1]};
		tr_re      = {1'b0, rw_re} - {2'b00, dvs_q};
		tr_im      = {1'b0, rw_im} - {2'b00, dvs_q};
		ge_re      = !tr_re[DIV_W+1];
		ge_im      = !tr_im[DIV_W+1];
		rem_re_nxt = ge_re ? tr_re[DIV_W-1:0] : rw_re[DIV_W-1:0];
		rem_im_nxt = ge_im ? tr_im[DIV_W-1:0] : rw_im[DIV_W-1:0];
		q_re       = neg_re_q ? -$signed(nm_re_q) : $signed(nm_re_q);
		q_im       = neg_im_q ? -$signed(nm_im_q) : $signed(nm_im_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LS_IDLE;
			col_q   <= '0;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				LS_IDLE: begin
					if (ctrl.div_start) begin
						col_q   <= '0;
						state_q <= LS_LOAD;
					end
				end
				LS_LOAD: begin
					nm_re_q  <= mag_re;
					nm_im_q  <= mag_im;
					neg_re_q <= num_re[NUM_W-1];
					neg_im_q <= num_im[NUM_W-1];
					rem_re_q <= '0;
					rem_im_q <= '0;
					dvs_q    <= dvs;
					cnt_q    <= '0;
					state_q  <= LS_DIV;
				end
				LS_DIV: begin
					nm_re_q  <= {nm_re_q[NUM_W-2:0], ge_re};
					nm_im_q  <= {nm_im_q[NUM_W-2:0], ge_im};
					rem_re_q <= rem_re_nxt;
					rem_im_q <= rem_im_nxt;
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						state_q <= LS_STORE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				LS_STORE: begin
					res_re[col_q] <= sce_pkg::ENTRY_W'(q_re);
					res_im[col_q] <= sce_pkg::ENTRY_W'(q_im);
					if (col_q == COL_W'(NUM_CH - 1)) begin
						done    <= 1'b1;
						state_q <= LS_IDLE;
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= LS_LOAD;
					end
				end
				default: state_q <= LS_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/sce_merge.sv =====
// Output stage: gathers the rows from all lanes and sends the matrix
// one entry per transfer in row-major order. Depends on sce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sce_merge #(
	parameter int NUM_CH = sce_pkg::NUM_CH_DEF
) (
	input  wire                                                  clk,
	input  wire                                                  arst_n,
	input  wire                                                  load,
	input  wire                                                  win_ok,
	input  wire [NUM_CH-1:0][NUM_CH-1:0][sce_pkg::ENTRY_W-1:0]   res_re,
	input  wire [NUM_CH-1:0][NUM_CH-1:0][sce_pkg::ENTRY_W-1:0]   res_im,
	output logic                                                 m_tvalid,
	input  wire                                                  m_tready,
	output logic [sce_pkg::OUT_DATA_W-1:0]                       m_tdata,
	output logic [0:0]                                           m_tuser,
	output logic                                                 m_tlast,
	output logic                                                 done
);

	localparam int COL_W = $clog2(NUM_CH);
	localparam int EW    = sce_pkg::ENTRY_W;
	localparam int IW    = sce_pkg::IDX_W;

	logic [COL_W-1:0] row_q, col_q, nrow, ncol;
	logic             ok_q, xfer, is_last;
	logic [EW-1:0]    sel_re, sel_im;

	assign xfer    = m_tvalid && m_tready;
	assign is_last = (row_q == COL_W'(NUM_CH - 1)) && (col_q == COL_W'(NUM_CH - 1));
	assign done    = xfer && m_tlast;

	always_comb begin
		if (load) begin
			nrow = '0;
			ncol = '0;
		end else if (col_q == COL_W'(NUM_CH - 1)) begin
			nrow = row_q + 1'b1;
			ncol = '0;
		end else begin
			nrow = row_q;
			ncol = col_q + 1'b1;
		end
		sel_re = res_re[nrow][ncol];
		sel_im = res_im[nrow][ncol];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			m_tlast  <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
			ok_q     <= 1'b0;
		end else if (load || (xfer && !is_last)) begin
			// A gated window still goes out in full, with zero entries.
			if (load) begin
				ok_q <= win_ok;
			end
			m_tvalid   <= 1'b1;
			row_q      <= nrow;
			col_q      <= ncol;
			m_tlast    <= (nrow == COL_W'(NUM_CH - 1)) && (ncol == COL_W'(NUM_CH - 1));
			m_tuser[0] <= load ? win_ok : ok_q;
			m_tdata    <= {2'b00,
				((load ? win_ok : ok_q) ? sel_im : EW'(0)),
				((load ? win_ok : ok_q) ? sel_re : EW'(0)),
				IW'(ncol), IW'(nrow)};
		end else if (xfer) begin
			m_tvalid <= 1'b0;
			m_tlast  <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== sv/spatial_covariance_estimator_core.sv =====
// Top level of the spatial covariance estimator: configuration registers,
// sample history memory, window control, lanes and output stage.
// Depends on sce_pkg, sce_lane and sce_merge.
//
//   Channel  Dir  Signals                              Content
//   s_       in   s_tvalid s_tready s_tdata s_tuser    one sample vector per transfer
//   m_       out  m_tvalid m_tready m_tdata m_tuser    one matrix entry per transfer
//                 m_tlast
//   APB      in   psel penable pwrite paddr pwdata     four registers at 0x0..0xC
//                 prdata pready
//
// A sample passes through accept with history read, products and accumulate.
// A sample that closes a window then runs the per-lane restoring divider and its
// hand-over to the output stage, followed by NUM_CH*NUM_CH output transfers.
// s_tready is low while a sample or a matrix is in flight; m_tready stalls only
// the output stage. Reset clears the sums and counters; the history memory is
// not cleared, since an entry is read only after the window has filled.
`timescale 1ns / 1ps
`default_nettype none

module spatial_covariance_estimator_core #(
	parameter int NUM_CH       = sce_pkg::NUM_CH_DEF,
	parameter int MAX_SNAPSHOT = sce_pkg::MAX_SNAPSHOT_DEF,
	parameter int SAMPLE_BITS  = sce_pkg::SAMPLE_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [127:0] s_tdata,   // sample_real [63:0], sample_imag [127:64]
	input  wire [1:0]   s_tuser,   // tag_valid [0], tag_invalid [1]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata,   // row_index [1:0], col_index [3:2], entry_real [36:4],
	                               // entry_imag [69:37], zero [71:70]
	output logic [0:0]  m_tuser,   // window_valid [0]
	output logic        m_tlast,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire [3:0]   paddr,
	input  wire [31:0]  pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int WW     = sce_pkg::WORD_W;
	localparam int LEN_W  = $clog2(MAX_SNAPSHOT + 1);
	localparam int PTR_W  = $clog2(MAX_SNAPSHOT);
	localparam int ADR_W  = LEN_W + 1;
	localparam int SUM_W  = 2 * SAMPLE_BITS + 1 + $clog2(MAX_SNAPSHOT);
	localparam int EW     = sce_pkg::ENTRY_W;

	// Configuration registers.
	logic [sce_pkg::SNAP_W-1:0] snap_q;
	logic [sce_pkg::OVL_W-1:0]  ovl_q;
	logic                       fb_q;
	logic [sce_pkg::GATE_W-1:0] gate_q;
	logic                       wr_en, restart;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign restart = wr_en && (paddr[3:2] != sce_pkg::REG_FB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_q <= sce_pkg::SNAP_RESET;
			ovl_q  <= '0;
			fb_q   <= 1'b0;
			gate_q <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				sce_pkg::REG_SNAPSHOT: snap_q <= pwdata[sce_pkg::SNAP_W-1:0];
				sce_pkg::REG_OVERLAP:  ovl_q  <= pwdata[sce_pkg::OVL_W-1:0];
				sce_pkg::REG_FB:       fb_q   <= pwdata[0];
				sce_pkg::REG_GATING:   gate_q <= pwdata[sce_pkg::GATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			sce_pkg::REG_SNAPSHOT: prdata = 32'(snap_q);
			sce_pkg::REG_OVERLAP:  prdata = 32'(ovl_q);
			sce_pkg::REG_FB:       prdata = 32'(fb_q);
			sce_pkg::REG_GATING:   prdata = 32'(gate_q);
			default:               prdata = '0;
		endcase
	end

	// Effective window length, overlap and hop.
	logic [LEN_W-1:0] len, ovl, hop_len;
	logic             gate_on;

	always_comb begin
		if (snap_q == '0) begin
			len = LEN_W'(1);
		end else if (32'(snap_q) > MAX_SNAPSHOT) begin
			len = LEN_W'(MAX_SNAPSHOT);
		end else begin
			len = LEN_W'(snap_q);
		end
		if (32'(ovl_q) > 32'(len) - 1) begin
			ovl = len - 1'b1;
		end else begin
			ovl = LEN_W'(ovl_q);
		end
		hop_len = len - ovl;
		gate_on = ((gate_q == sce_pkg::GATE_START_INVALID) ||
			(gate_q == sce_pkg::GATE_START_VALID)) && (ovl == '0);
	end

	// Window bookkeeping for the sample being offered.
	typedef enum logic [2:0] {ST_IDLE, ST_PROD, ST_ACC, ST_DIV, ST_OUT} core_state_t;

	core_state_t      state_q;
	logic [LEN_W-1:0] fill_q, hop_q, fill_nxt, hop_nxt;
	logic [PTR_W-1:0] wp_q, rd_ptr;
	logic [ADR_W-1:0] rd_full;
	logic             sv_q, wok_q, sv_nxt, wok_nxt, sub, emit, accept;
	logic             sub_q, emit_q, emit_ok_q;
	logic             tag_v, tag_i;

	assign tag_v  = s_tuser[0];
	assign tag_i  = s_tuser[1];
	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		sv_nxt  = sv_q;
		wok_nxt = wok_q;
		if (gate_on) begin
			if (hop_q == '0) begin
				if (tag_i) begin
					sv_nxt = 1'b0;
				end else if (tag_v) begin
					sv_nxt = 1'b1;
				end
				wok_nxt = sv_nxt;
			end else if (tag_i || tag_v) begin
				wok_nxt = 1'b0;
				sv_nxt  = !tag_i;
			end
		end else begin
			wok_nxt = 1'b1;
		end
		sub      = (fill_q >= len);
		fill_nxt = sub ? fill_q : fill_q + 1'b1;
		hop_nxt  = (hop_q < len) ? hop_q + 1'b1 : hop_q;
		emit     = (fill_nxt >= len) && (hop_nxt >= hop_len);
		if (ADR_W'(wp_q) >= ADR_W'(len)) begin
			rd_full = ADR_W'(wp_q) - ADR_W'(len);
		end else begin
			rd_full = ADR_W'(wp_q) + ADR_W'(MAX_SNAPSHOT) - ADR_W'(len);
		end
		rd_ptr = rd_full[PTR_W-1:0];
	end

	logic all_done, merge_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			hop_q     <= '0;
			wp_q      <= '0;
			sv_q      <= 1'b1;
			wok_q     <= 1'b1;
			sub_q     <= 1'b0;
			emit_q    <= 1'b0;
			emit_ok_q <= 1'b0;
		end else if (restart) begin
			fill_q <= '0;
			hop_q  <= '0;
			wp_q   <= '0;
			sv_q   <= (pwdata[sce_pkg::GATE_W-1:0] != sce_pkg::GATE_START_INVALID) ||
				(paddr[3:2] != sce_pkg::REG_GATING) ?
				((paddr[3:2] == sce_pkg::REG_GATING) ? 1'b1 :
				(gate_q != sce_pkg::GATE_START_INVALID)) : 1'b0;
			wok_q  <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q    <= fill_nxt;
						hop_q     <= emit ? '0 : hop_nxt;
						wp_q      <= (wp_q == PTR_W'(MAX_SNAPSHOT - 1)) ? '0 : wp_q + 1'b1;
						sv_q      <= sv_nxt;
						wok_q     <= emit ? 1'b1 : wok_nxt;
						sub_q     <= sub;
						emit_q    <= emit;
						emit_ok_q <= wok_nxt;
						state_q   <= ST_PROD;
					end
				end
				ST_PROD: state_q <= ST_ACC;
				ST_ACC:  state_q <= emit_q ? ST_DIV : ST_IDLE;
				ST_DIV: begin
					if (all_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (merge_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Sample history. The departing sample is read as the new one is written.
	logic [2*WW-1:0] hist_mem [MAX_SNAPSHOT];
	logic [2*WW-1:0] old_q, new_q, old_w;

	always_ff @(posedge clk) begin
		if (accept) begin
			hist_mem[wp_q] <= s_tdata;
			old_q          <= hist_mem[rd_ptr];
			new_q          <= s_tdata;
		end
	end

	// Nothing leaves the window until it has filled.
	assign old_w = sub_q ? old_q : '0;

	sce_pkg::lane_ctrl_t ctrl;

	assign ctrl.clear     = restart;
	assign ctrl.acc       = (state_q == ST_ACC);
	assign ctrl.div_start = (state_q == ST_ACC) && emit_q;
	assign ctrl.fb        = fb_q;

	logic [NUM_CH-1:0][NUM_CH-1:0][SUM_W-1:0] own_re, own_im;
	logic [NUM_CH-1:0][NUM_CH-1:0][EW-1:0]    res_re, res_im;
	logic [NUM_CH-1:0]                        lane_done;

	genvar a;
	for (a = 0; a < NUM_CH; a++) begin : g_lane
		sce_lane #(
			.NUM_CH      (NUM_CH),
			.SAMPLE_BITS (SAMPLE_BITS),
			.SUM_W       (SUM_W),
			.LEN_W       (LEN_W),
			.LANE        (a)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.len    (len),
			.new_re (new_q[WW-1:0]),
			.new_im (new_q[2*WW-1:WW]),
			.old_re (old_w[WW-1:0]),
			.old_im (old_w[2*WW-1:WW]),
			.mir_re (own_re[NUM_CH-1-a]),
			.mir_im (own_im[NUM_CH-1-a]),
			.own_re (own_re[a]),
			.own_im (own_im[a]),
			.res_re (res_re[a]),
			.res_im (res_im[a]),
			.done   (lane_done[a])
		);
	end

	assign all_done = &lane_done;

	sce_merge #(
		.NUM_CH (NUM_CH)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     ((state_q == ST_DIV) && all_done),
		.win_ok   (emit_ok_q),
		.res_re   (res_re),
		.res_im   (res_im),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.done     (merge_done)
	);

endmodule

`default_nettype wire
